### design/owm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// owm_pkg: shared types for the single-wire bus master
// Request and result payloads, configuration record and phase codes.
// ---------------------------------------------------------------------------
package owm_pkg;

  localparam int unsigned TickW   = 16;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } owm_op_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RESET_LOW     = 3'd0,
    CFG_PRESENCE_WAIT = 3'd1,
    CFG_RESET_TAIL    = 3'd2,
    CFG_WRITE_ONE_LOW = 3'd3,
    CFG_WRITE_ZERO_LOW = 3'd4,
    CFG_WRITE_SLOT    = 3'd5,
    CFG_READ_LOW      = 3'd6,
    CFG_READ_SLOT     = 3'd7
  } owm_cfg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_RLOW  = 3'd1,
    PH_RWAIT = 3'd2,
    PH_RTAIL = 3'd3,
    PH_WRITE = 3'd4,
    PH_READ  = 3'd5
  } owm_phase_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] write_data;
    logic       line_level;
  } owm_in_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic [1:0] presence_bits;
  } owm_out_t;

  typedef struct packed {
    logic [TickW-1:0] reset_low_ticks;
    logic [TickW-1:0] presence_wait_ticks;
    logic [TickW-1:0] reset_tail_ticks;
    logic [TickW-1:0] write_one_low_ticks;
    logic [TickW-1:0] write_zero_low_ticks;
    logic [TickW-1:0] write_slot_ticks;
    logic [TickW-1:0] read_low_ticks;
    logic [TickW-1:0] read_slot_ticks;
  } owm_cfg_t;

  // zero duration counts as one tick
  function automatic logic [TickW-1:0] at_least_one(input logic [TickW-1:0] v);
    at_least_one = (v == '0) ? {{(TickW-1){1'b0}}, 1'b1} : v;
  endfunction

endpackage
`default_nettype wire

### design/owm_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// owm_cfg_regs: timing register bank
// Eight 16-bit tick counts, written through a plain write port.
// ---------------------------------------------------------------------------
module owm_cfg_regs
  import owm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [TickW-1:0]   cfg_wdata,
  output owm_cfg_t                cfg_o
);

  owm_cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (owm_cfg_idx_t'(cfg_index))
        CFG_RESET_LOW:      cfg_nxt.reset_low_ticks      = cfg_wdata;
        CFG_PRESENCE_WAIT:  cfg_nxt.presence_wait_ticks  = cfg_wdata;
        CFG_RESET_TAIL:     cfg_nxt.reset_tail_ticks     = cfg_wdata;
        CFG_WRITE_ONE_LOW:  cfg_nxt.write_one_low_ticks  = cfg_wdata;
        CFG_WRITE_ZERO_LOW: cfg_nxt.write_zero_low_ticks = cfg_wdata;
        CFG_WRITE_SLOT:     cfg_nxt.write_slot_ticks     = cfg_wdata;
        CFG_READ_LOW:       cfg_nxt.read_low_ticks       = cfg_wdata;
        CFG_READ_SLOT:      cfg_nxt.read_slot_ticks      = cfg_wdata;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_ticks      <= 16'd500;
      cfg_r.presence_wait_ticks  <= 16'd100;
      cfg_r.reset_tail_ticks     <= 16'd400;
      cfg_r.write_one_low_ticks  <= 16'd10;
      cfg_r.write_zero_low_ticks <= 16'd60;
      cfg_r.write_slot_ticks     <= 16'd100;
      cfg_r.read_low_ticks       <= 16'd10;
      cfg_r.read_slot_ticks      <= 16'd125;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule
`default_nettype wire

### design/owm_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// owm_core: bus sequencer
// Phase, tick counter and shift registers; one tick per accepted request.
// ---------------------------------------------------------------------------
module owm_core
  import owm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     tick_en,
  input  wire owm_in_t  req_i,
  input  wire owm_cfg_t cfg_i,
  output owm_out_t      res_o
);

  owm_phase_t       phase_r, phase_nxt;
  logic [TickW-1:0] tick_count_r, tick_count_nxt;
  logic [2:0]       bit_index_r, bit_index_nxt;
  logic [7:0]       shift_byte_r, shift_byte_nxt;
  logic [7:0]       read_result_r, read_result_nxt;
  logic [1:0]       presence_r, presence_nxt;

  logic             drive;
  logic             done;
  logic [TickW:0]   cnt_inc;
  logic [TickW-1:0] low_t;
  logic [TickW-1:0] slot_t;
  logic [TickW:0]   samp_pt;

  always_comb begin
    phase_nxt       = phase_r;
    tick_count_nxt  = tick_count_r;
    bit_index_nxt   = bit_index_r;
    shift_byte_nxt  = shift_byte_r;
    read_result_nxt = read_result_r;
    presence_nxt    = presence_r;
    drive           = 1'b0;
    done            = 1'b0;
    low_t           = '0;
    slot_t          = '0;
    samp_pt         = '0;

    // command start, only from idle
    if (phase_r == PH_IDLE && owm_op_t'(req_i.operation) != OP_TICK) begin
      tick_count_nxt = '0;
      bit_index_nxt  = '0;
      unique case (owm_op_t'(req_i.operation))
        OP_RESET: begin
          phase_nxt    = PH_RLOW;
          presence_nxt = 2'b00;
        end
        OP_WRITE: begin
          phase_nxt      = PH_WRITE;
          shift_byte_nxt = req_i.write_data;
        end
        OP_READ: begin
          phase_nxt      = PH_READ;
          shift_byte_nxt = 8'h00;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end

    cnt_inc = {1'b0, tick_count_nxt} + {{TickW{1'b0}}, 1'b1};

    unique case (phase_nxt)
      PH_RLOW: begin
        drive          = 1'b1;
        tick_count_nxt = cnt_inc[TickW-1:0];
        if (cnt_inc >= {1'b0, at_least_one(cfg_i.reset_low_ticks)}) begin
          phase_nxt      = PH_RWAIT;
          tick_count_nxt = '0;
        end
      end
      PH_RWAIT: begin
        tick_count_nxt = cnt_inc[TickW-1:0];
        if (cnt_inc >= {1'b0, at_least_one(cfg_i.presence_wait_ticks)}) begin
          presence_nxt[0] = req_i.line_level;
          phase_nxt       = PH_RTAIL;
          tick_count_nxt  = '0;
        end
      end
      PH_RTAIL: begin
        tick_count_nxt = cnt_inc[TickW-1:0];
        if (cnt_inc >= {1'b0, at_least_one(cfg_i.reset_tail_ticks)}) begin
          presence_nxt[1] = req_i.line_level;
          phase_nxt       = PH_IDLE;
          tick_count_nxt  = '0;
          done            = 1'b1;
        end
      end
      PH_WRITE: begin
        low_t  = shift_byte_nxt[bit_index_nxt] ? at_least_one(cfg_i.write_one_low_ticks)
                                               : at_least_one(cfg_i.write_zero_low_ticks);
        slot_t = at_least_one(cfg_i.write_slot_ticks);
        drive  = (tick_count_nxt < low_t);
        tick_count_nxt = cnt_inc[TickW-1:0];
        if (cnt_inc >= {1'b0, slot_t}) begin
          tick_count_nxt = '0;
          if (bit_index_nxt == 3'd7) begin
            phase_nxt     = PH_IDLE;
            bit_index_nxt = '0;
            done          = 1'b1;
          end else begin
            bit_index_nxt = bit_index_nxt + 3'd1;
          end
        end
      end
      PH_READ: begin
        low_t   = at_least_one(cfg_i.read_low_ticks);
        slot_t  = at_least_one(cfg_i.read_slot_ticks);
        // sample point sits one low time after release, clipped to the slot
        samp_pt = {low_t, 1'b0};
        if (samp_pt > {1'b0, slot_t}) begin
          samp_pt = {1'b0, slot_t};
        end
        drive = (tick_count_nxt < low_t);
        if (cnt_inc == samp_pt) begin
          shift_byte_nxt[bit_index_nxt] = shift_byte_nxt[bit_index_nxt] | req_i.line_level;
        end
        tick_count_nxt = cnt_inc[TickW-1:0];
        if (cnt_inc >= {1'b0, slot_t}) begin
          tick_count_nxt = '0;
          if (bit_index_nxt == 3'd7) begin
            read_result_nxt = shift_byte_nxt;
            phase_nxt       = PH_IDLE;
            bit_index_nxt   = '0;
            done            = 1'b1;
          end else begin
            bit_index_nxt = bit_index_nxt + 3'd1;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      tick_count_r  <= '0;
      bit_index_r   <= '0;
      shift_byte_r  <= '0;
      read_result_r <= '0;
      presence_r    <= '0;
    end else if (tick_en) begin
      phase_r       <= phase_nxt;
      tick_count_r  <= tick_count_nxt;
      bit_index_r   <= bit_index_nxt;
      shift_byte_r  <= shift_byte_nxt;
      read_result_r <= read_result_nxt;
      presence_r    <= presence_nxt;
    end
  end

  always_comb begin
    res_o.drive_low     = drive;
    res_o.busy_res      = (phase_nxt != PH_IDLE);
    res_o.done_res      = done;
    res_o.read_data     = read_result_nxt;
    res_o.presence_bits = presence_nxt;
  end

endmodule
`default_nettype wire

### design/owm_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// owm_out_buf: result register with skid stage
// Holds up to two results so the request side can take one more while the output stalls.
// ---------------------------------------------------------------------------
module owm_out_buf
  import owm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push_i,
  input  wire owm_out_t data_i,
  output logic          can_push_o,
  output logic          out_valid,
  input  wire logic     out_ready,
  output owm_out_t      out_data
);

  logic     main_vld_r, main_vld_nxt;
  logic     skid_vld_r, skid_vld_nxt;
  owm_out_t main_r, main_nxt;
  owm_out_t skid_r, skid_nxt;
  logic     take;

  assign take       = main_vld_r && out_ready;
  assign can_push_o = !skid_vld_r;

  always_comb begin
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    priority if (skid_vld_r) begin
      if (take) begin
        main_nxt     = skid_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (push_i && main_vld_r && !take) begin
      skid_nxt     = data_i;
      skid_vld_nxt = 1'b1;
    end else if (push_i) begin
      main_nxt     = data_i;
      main_vld_nxt = 1'b1;
    end else if (take) begin
      main_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = main_vld_r;
  assign out_data  = main_r;

endmodule
`default_nettype wire

### design/onewire_bus_master.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// onewire_bus_master: tick-driven single-wire bus master
// Each request is one tick of the bus timebase; each yields one result.
// ---------------------------------------------------------------------------
// Usage
//   in_*   : one request per bus tick: operation (tick only, bus reset,
//            write byte, read byte), write byte and the sampled line level.
//            A command is taken only on a tick that starts idle.
//   out_*  : one result per request: drive_low for the pin, busy, done,
//            last read byte and the two presence bits.
//   cfg_*  : slot timing registers in ticks, written while idle.
// Result  : a request accepted at edge N is written into the result buffer at N
//           and shown on out_* unless older results wait; the sequencer state is updated at N.
// Throughput: one request per cycle while in_ready is high, bounded by the update of
//           the phase/tick counter loop in owm_core on each accepted request.
// Stall   : a two-entry result buffer sits on the out side; with out_ready
//           low, one further request is taken, then in_ready drops until
//           the receiver takes a result.
// Reset   : synchronous, active low. Phase idle, counters and stored bytes
//           cleared, timing registers back to their defaults, buffer empty.
// ---------------------------------------------------------------------------
module onewire_bus_master
  import owm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // request channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire owm_in_t            in_data,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output owm_out_t                out_data,
  // configuration write port
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [TickW-1:0]   cfg_wdata
);

  owm_cfg_t cfg;
  owm_out_t core_res;
  logic     req_fire;
  logic     buf_room;

  // a request is a tick: state advances only when one is taken
  assign in_ready = buf_room;
  assign req_fire = in_valid && buf_room;

  owm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  owm_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .tick_en (req_fire),
    .req_i   (in_data),
    .cfg_i   (cfg),
    .res_o   (core_res)
  );

  // result register plus skid entry
  owm_out_buf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (req_fire),
    .data_i     (core_res),
    .can_push_o (buf_room),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

### design/owm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// owm_checker: port-level checks for the bus master
// Output handshake and result consistency, bound to the top level.
// ---------------------------------------------------------------------------
module owm_checker
  import owm_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_ready,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire owm_out_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // back-pressure only with a result waiting
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("in_ready low with empty result register");

  // an operation that completes leaves the bus idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.done_res && out_data.busy_res))
    else $error("done and busy together");

  // buffer empty straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind onewire_bus_master owm_checker u_owm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
